// ----- hw/rtl/tlpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared types, constants and helpers of the two-level page table mapper.
// ----------------------------------------------------------------------------
package tlpt_pkg;

  // Number of page tables that can be allocated behind the directory.
  localparam int TABLE_SLOTS = 16;

  localparam int ENT_W       = 10;
  localparam int DIR_DEPTH   = 1 << ENT_W;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int TADDR_W     = SLOT_W + ENT_W;
  localparam int TABLE_DEPTH = TABLE_SLOTS * DIR_DEPTH;

  // Entry flag bits.
  localparam logic [11:0] FLAG_P = 12'h001;
  localparam logic [11:0] FLAG_W = 12'h002;
  localparam logic [11:0] FLAG_U = 12'h004;

  typedef enum logic {
    ACT_MAP    = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STAT_MAPPED = 2'd0,
    STAT_HIT    = 2'd1,
    STAT_MISS   = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_TBL
  } state_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] virt_addr;
    logic [19:0] phys_frame;
    logic [11:0] perm;
    logic        segment_last;
  } item_t;

  typedef struct packed {
    logic [31:0] entry_value;
    status_t     status;
    logic        table_allocated;
    logic [4:0]  tables_used;
    logic        segment_done;
  } result_t;

  // Table count as reported on the result, kept to five bits.
  function automatic logic [4:0] used_bits(input logic [CNT_W-1:0] n);
    logic [31:0] w;
    w = 32'(n);
    return w[4:0];
  endfunction

endpackage

// ----- hw/rtl/tlpt_ram.sv -----
// ----------------------------------------------------------------------------
// tlpt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tlpt_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/tlpt_walk.sv -----
// ----------------------------------------------------------------------------
// tlpt_walk
// Page walk sequencer: owns the directory and table memories, the slot
// counter and the clearing pass, and produces one result per item.
// ----------------------------------------------------------------------------
module tlpt_walk
  import tlpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [19:0] dir_frame,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       in_item,
  output logic        res_valid,
  input  logic        res_ready,
  output result_t     res
);

  state_t              state;
  state_t              state_next;
  item_t               item;
  logic [TADDR_W-1:0]  clr_cnt;
  logic [CNT_W-1:0]    next_slot;

  logic                dir_we;
  logic                dir_re;
  logic [ENT_W-1:0]    dir_waddr;
  logic [ENT_W-1:0]    dir_raddr;
  logic [31:0]         dir_wdata;
  logic [31:0]         dir_rdata;

  logic                tbl_we;
  logic                tbl_re;
  logic [TADDR_W-1:0]  tbl_waddr;
  logic [TADDR_W-1:0]  tbl_raddr;
  logic [31:0]         tbl_wdata;
  logic [31:0]         tbl_rdata;

  logic                pde_present;
  logic [19:0]         slot_off;
  logic                old_ok;
  logic [SLOT_W-1:0]   old_slot;
  logic                do_alloc;
  logic                walk_ok;
  logic [SLOT_W-1:0]   walk_slot;
  logic [19:0]         new_frame;
  logic [31:0]         map_entry;
  logic [ENT_W-1:0]    ti;

  tlpt_ram #(.W(32), .DEPTH(DIR_DEPTH), .AW(ENT_W)) u_dir (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .re    (dir_re),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  tlpt_ram #(.W(32), .DEPTH(TABLE_DEPTH), .AW(TADDR_W)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Directory entry decode. A present entry only counts when its frame lies
  // inside the table area that follows the current directory frame.
  always_comb begin
    ti          = item.virt_addr[21:12];
    pde_present = dir_rdata[0];
    slot_off    = dir_rdata[31:12] - dir_frame - 20'd1;
    old_ok      = pde_present && (slot_off < 20'(TABLE_SLOTS));
    old_slot    = slot_off[SLOT_W-1:0];
    do_alloc    = !pde_present && (next_slot < CNT_W'(TABLE_SLOTS));
    walk_ok     = do_alloc || old_ok;
    walk_slot   = do_alloc ? next_slot[SLOT_W-1:0] : old_slot;
    new_frame   = dir_frame + 20'd1 + 20'(next_slot);
    map_entry   = {item.phys_frame, 12'h000} | {20'h00000, item.perm}
                | {20'h00000, FLAG_P};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == TADDR_W'(TABLE_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DIR;
        end
      end
      S_DIR: begin
        if (item.action == ACT_LOOKUP && old_ok) begin
          state_next = S_TBL;
        end else if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      S_TBL: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready            = 1'b0;
    res_valid           = 1'b0;
    res.entry_value     = 32'h0;
    res.status          = STAT_MISS;
    res.table_allocated = 1'b0;
    res.tables_used     = used_bits(next_slot);
    res.segment_done    = item.segment_last;
    dir_we              = 1'b0;
    dir_re              = 1'b0;
    dir_waddr           = item.virt_addr[31:22];
    dir_raddr           = in_item.virt_addr[31:22];
    dir_wdata           = {new_frame, 12'h000} | {20'h00000, FLAG_P | FLAG_W | FLAG_U};
    tbl_we              = 1'b0;
    tbl_re              = 1'b0;
    tbl_waddr           = {walk_slot, ti};
    tbl_raddr           = {old_slot, ti};
    tbl_wdata           = map_entry;
    unique case (state)
      S_CLEAR: begin
        dir_we    = 1'b1;
        dir_waddr = clr_cnt[ENT_W-1:0];
        dir_wdata = 32'h0;
        tbl_we    = 1'b1;
        tbl_waddr = clr_cnt;
        tbl_wdata = 32'h0;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        dir_re   = in_valid;
      end
      S_DIR: begin
        if (item.action == ACT_MAP) begin
          res_valid = 1'b1;
          if (walk_ok) begin
            res.entry_value     = map_entry;
            res.status          = STAT_MAPPED;
            res.table_allocated = do_alloc;
            tbl_we              = res_ready;
            dir_we              = do_alloc && res_ready;
            if (do_alloc) begin
              res.tables_used = used_bits(next_slot + CNT_W'(1));
            end
          end else begin
            res.status = STAT_FULL;
          end
        end else if (old_ok) begin
          tbl_re = 1'b1;
        end else begin
          res_valid  = 1'b1;
          res.status = STAT_MISS;
        end
      end
      S_TBL: begin
        res_valid = 1'b1;
        if (tbl_rdata[0]) begin
          res.entry_value = tbl_rdata;
          res.status      = STAT_HIT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == S_CLEAR) begin
      clr_cnt <= clr_cnt + TADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_slot <= '0;
    end else if (state == S_DIR && dir_we) begin
      next_slot <= next_slot + CNT_W'(1);
    end
  end

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    next_slot <= CNT_W'(TABLE_SLOTS))
    else $error("slot counter ran past the table area");

  a_tbl_write_mapped: assert property (@(posedge clk) disable iff (rst)
    (tbl_we && state != S_CLEAR) |-> (res_valid && res_ready && res.status == STAT_MAPPED))
    else $error("table written outside a delivered map");

  a_alloc_bumps: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIR && dir_we) |=> next_slot == $past(next_slot) + CNT_W'(1))
    else $error("allocation did not advance the slot counter");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == STAT_FULL) |-> (res.entry_value == 32'h0
      && !res.table_allocated && !dir_we && !tbl_we))
    else $error("overflow result wrote or reported state");

endmodule

// ----- hw/rtl/two_level_page_table_mapper.sv -----
// ----------------------------------------------------------------------------
// two_level_page_table_mapper
// Builds and walks a 32-bit two-level page table held in on-chip memory.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over its memories; no transfer
// is taken on the input side during that time, while writes to the directory
// frame register are accepted as always. Each input transfer then gives
// exactly one output transfer. A map is accepted with the directory read
// and then does the directory and table writes; a lookup that finds a table
// adds a table read after the directory read, as the walk uses the two
// synchronous memories in series. The result sits in an output register, so
// the next item is taken while an earlier result still waits; a new result
// only stalls the walk when that register is still full. Table slots are
// handed out by a bump counter and never freed; once they run out a map that
// needs a new table answers "no free slot" and writes nothing. The directory
// frame register should only be changed while the block is idle.
// ----------------------------------------------------------------------------
module two_level_page_table_mapper
  import tlpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  // Directory frame register.
  input  logic        cfg_wen,
  input  logic [19:0] cfg_wdata,

  // Input items.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // virt_addr[31:0], phys_frame[51:32], perm[63:52]
  input  logic [0:0]  s_tuser,   // action[0]
  input  logic        s_tlast,   // segment_last

  // Result items.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // entry_value[31:0], table_allocated[32],
                                 // tables_used[37:33], zero fill[39:38]
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast    // segment_done
);

  logic [19:0] dir_frame;
  item_t       in_item;
  logic        res_valid;
  logic        res_ready;
  result_t     res;
  result_t     out_res;

  // The directory frame is a plain register; writes land on the next edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      dir_frame <= 20'h00000;
    end else if (cfg_wen) begin
      dir_frame <= cfg_wdata;
    end
  end

  // Unpack the input transfer into an item.
  always_comb begin
    in_item.action       = action_t'(s_tuser[0]);
    in_item.virt_addr    = s_tdata[31:0];
    in_item.phys_frame   = s_tdata[51:32];
    in_item.perm         = s_tdata[63:52];
    in_item.segment_last = s_tlast;
  end

  tlpt_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .dir_frame (dir_frame),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The output register accepts a new result when it is empty or being
  // drained in this same cycle.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.tables_used, out_res.table_allocated,
                    out_res.entry_value};
  assign m_tuser = out_res.status;
  assign m_tlast = out_res.segment_done;

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the two-level page table mapper.
// ----------------------------------------------------------------------------
// Map and lookup items go in on the input stream. A scoreboard keeps its own
// page directory, table store and slot counter, works out the answer of each
// accepted item and compares every result transfer field by field. A directed
// opening covers the corner cases. Random phases with different directory
// frames follow, so that the walk also meets directory pointers that fall
// outside the table area. Both stream sides stall and idle at random.
// ----------------------------------------------------------------------------
module tb;
  import tlpt_pkg::*;

  // The clearing pass after reset moves no transfer at all, so the stall limit
  // sits well above the length of that pass.
  localparam int STALL_LIMIT  = 3 * TABLE_SLOTS * DIR_DEPTH + 1000;
  localparam int PHASE_ITEMS  = 286;
  localparam int NUM_PHASES   = 5;
  localparam int MAX_REPORTED = 10;

  // Scoreboard: a behavioral copy of the page table state and the queue of
  // answers that the block still owes.
  class page_walk_scoreboard;
    logic [31:0] dir_mem [DIR_DEPTH];
    logic [31:0] tbl_mem [TABLE_DEPTH];
    int          next_slot;
    logic [19:0] dir_frame;
    result_t     expected_q [$];
    int          mismatches;
    int          n_status [4];
    int          n_stray;
    int          n_alloc;
    int          n_frames;

    function new();
      foreach (dir_mem[i]) dir_mem[i] = '0;
      foreach (tbl_mem[i]) tbl_mem[i] = '0;
      foreach (n_status[i]) n_status[i] = 0;
      next_slot  = 0;
      dir_frame  = '0;
      mismatches = 0;
      n_stray    = 0;
      n_alloc    = 0;
      n_frames   = 0;
    endfunction

    function void set_dir_frame(logic [19:0] frame);
      dir_frame = frame;
      n_frames++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Walks the directory and the table for one accepted item, updates the
    // copy of the state and queues the answer.
    function void note_item(item_t it);
      logic [9:0]  di;
      logic [9:0]  ti;
      logic [31:0] pde;
      logic [19:0] rel;
      int          slot;
      bit          have;
      result_t     r;
      di   = it.virt_addr[31:22];
      ti   = it.virt_addr[21:12];
      pde  = dir_mem[di];
      have = 0;
      slot = 0;
      r    = '0;
      r.segment_done = it.segment_last;
      // A present entry only counts when its frame lies in the table area
      // of the current directory frame.
      if (pde[0]) begin
        rel = pde[31:12] - dir_frame - 20'd1;
        if (rel < TABLE_SLOTS) begin
          have = 1;
          slot = int'(rel);
        end else begin
          n_stray++;
        end
      end
      if (it.action == ACT_MAP) begin
        if (!pde[0] && next_slot < TABLE_SLOTS) begin
          slot = next_slot;
          next_slot++;
          dir_mem[di] = {dir_frame + 20'(slot) + 20'd1, FLAG_P | FLAG_W | FLAG_U};
          r.table_allocated = 1'b1;
          have = 1;
          n_alloc++;
        end
        if (have) begin
          r.entry_value = {it.phys_frame, it.perm | FLAG_P};
          tbl_mem[slot * DIR_DEPTH + int'(ti)] = r.entry_value;
          r.status = STAT_MAPPED;
        end else begin
          r.status = STAT_FULL;
        end
      end else begin
        if (have && tbl_mem[slot * DIR_DEPTH + int'(ti)][0]) begin
          r.entry_value = tbl_mem[slot * DIR_DEPTH + int'(ti)];
          r.status = STAT_HIT;
        end else begin
          r.status = STAT_MISS;
        end
      end
      r.tables_used = 5'(next_slot);
      n_status[r.status]++;
      expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("ERROR: result with nothing expected: entry %h status %s",
                   got.entry_value, got.status.name());
        return;
      end
      want = expected_q.pop_front();
      if (got.entry_value !== want.entry_value || got.status !== want.status ||
          got.table_allocated !== want.table_allocated ||
          got.tables_used !== want.tables_used ||
          got.segment_done !== want.segment_done) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("ERROR: entry %h/%h status %0d/%0d alloc %0b/%0b used %0d/%0d last %0b/%0b %s",
                   want.entry_value, got.entry_value, want.status, got.status,
                   want.table_allocated, got.table_allocated,
                   want.tables_used, got.tables_used,
                   want.segment_done, got.segment_done, "(expected/actual)");
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic [19:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // virt_addr[31:0], phys_frame[51:32], perm[63:52]
  logic [0:0]  s_tuser;   // action[0]
  logic        s_tlast;   // segment_last
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // entry_value[31:0], table_allocated[32], tables_used[37:33]
  logic [1:0]  m_tuser;   // status[1:0]
  logic        m_tlast;   // segment_done

  page_walk_scoreboard sb;

  // Each side switches now and then into a stretch without any idling.
  bit s_quiet;
  bit m_quiet;

  // Directory indexes that the directed part allocates, plus the one that
  // finds the slots exhausted; the random part mostly walks these.
  logic [9:0] dir_pool [17];
  logic [9:0] ti_pool  [32];

  two_level_page_table_mapper i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: counts cycles in which neither side moves a transfer.
  int stall_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : int'($urandom_range(0, 14));
  endfunction

  function automatic item_t make_item(action_t act, logic [31:0] va, logic [19:0] frame,
                                      logic [11:0] perm, logic last);
    item_t it;
    it.action       = act;
    it.virt_addr    = va;
    it.phys_frame   = frame;
    it.perm         = perm;
    it.segment_last = last;
    return it;
  endfunction

  // Random items mostly land on allocated directory entries and a small set
  // of table indexes, so that lookups find what earlier maps wrote.
  function automatic item_t random_item();
    logic [9:0]  di;
    logic [9:0]  ti;
    logic [31:0] va;
    di = ($urandom_range(0, 4) != 0) ? dir_pool[$urandom_range(0, 16)] : 10'($urandom());
    ti = ($urandom_range(0, 9) < 7) ? ti_pool[$urandom_range(0, 31)] : 10'($urandom());
    va = {di, ti, 12'($urandom())};
    return make_item(($urandom_range(0, 99) < 45) ? ACT_LOOKUP : ACT_MAP, va,
                     20'($urandom()), 12'($urandom()), $urandom_range(0, 3) == 0);
  endfunction

  // One input transfer. The valid is only lowered when a gap follows, so it
  // never drops and rises within one step.
  task automatic send_item(item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) s_quiet = ~s_quiet;
    gap = draw_gap(s_quiet);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {it.perm, it.phys_frame, it.virt_addr};
    s_tuser  <= it.action;
    s_tlast  <= it.segment_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(it);
  endtask

  // Waits until every answer has come back and the block is quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_dir_frame(logic [19:0] frame);
    cfg_wen   <= 1'b1;
    cfg_wdata <= frame;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    sb.set_dir_frame(frame);
  endtask

  // Result side: random back-pressure, every accepted transfer is checked.
  initial begin
    int      gap;
    result_t got;
    m_quiet  = 0;
    m_tready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) m_quiet = ~m_quiet;
      gap = draw_gap(m_quiet);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got.entry_value     = m_tdata[31:0];
      got.table_allocated = m_tdata[32];
      got.tables_used     = m_tdata[37:33];
      got.status          = status_t'(m_tuser);
      got.segment_done    = m_tlast;
      sb.check_result(got);
    end
  end

  initial begin
    logic [19:0] phase_frames [NUM_PHASES];
    sb = new();
    rst       <= 1'b1;
    cfg_wen   <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    s_tlast   <= 1'b0;
    s_quiet   = 0;

    dir_pool[0]  = 10'd0;
    dir_pool[1]  = 10'd1023;
    for (int k = 0; k < 14; k++) dir_pool[k + 2] = 10'(2 + 73 * k);
    dir_pool[16] = 10'd600;
    ti_pool[0] = 10'd0;
    ti_pool[1] = 10'd1023;
    for (int k = 2; k < 32; k++) ti_pool[k] = 10'($urandom());

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // The top frame makes the slot frames wrap around to zero.
    write_dir_frame(20'hfffff);

    // Directed part. Lowest and highest addresses and values first.
    send_item(make_item(ACT_MAP,    32'h0000_0000, 20'h00000, 12'h000, 1'b0));
    send_item(make_item(ACT_MAP,    32'hffff_ffff, 20'hfffff, 12'hfff, 1'b1));
    send_item(make_item(ACT_LOOKUP, 32'hffff_ffff, 20'h00000, 12'h000, 1'b0));
    send_item(make_item(ACT_LOOKUP, 32'h0000_0000, 20'hfffff, 12'hfff, 1'b1));
    // Table present but the entry was never written.
    send_item(make_item(ACT_LOOKUP, 32'h0000_1000, 20'h00000, 12'h000, 1'b0));
    // Directory entry absent.
    send_item(make_item(ACT_LOOKUP, 32'h0040_0000, 20'h00000, 12'h000, 1'b0));
    // A map over an existing entry replaces it; the offset bits are ignored.
    send_item(make_item(ACT_MAP,    32'h0000_0fff, 20'habcde, 12'h5a4, 1'b0));
    send_item(make_item(ACT_LOOKUP, 32'h0000_0000, 20'h00000, 12'h000, 1'b1));
    // Use up the remaining table slots, then ask for one more.
    for (int k = 2; k < 16; k++)
      send_item(make_item(ACT_MAP, {dir_pool[k], 22'($urandom())}, 20'($urandom()),
                          12'($urandom()), 1'b0));
    send_item(make_item(ACT_MAP,    {dir_pool[16], 22'h12345}, 20'h54321, 12'h0f0, 1'b1));
    send_item(make_item(ACT_LOOKUP, {dir_pool[16], 22'h12345}, 20'h00000, 12'h000, 1'b0));

    // Random phases. Moving the directory frame down by two or up by one
    // leaves some directory pointers outside the table area; a random frame
    // strands nearly all of them, and the last phase restores the start.
    phase_frames[0] = 20'hfffff;
    phase_frames[1] = 20'hffffd;
    phase_frames[2] = 20'h00000;
    phase_frames[3] = 20'($urandom());
    phase_frames[4] = 20'hfffff;
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_dir_frame(phase_frames[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
    end

    settle();
    repeat (20) @(posedge clk);

    $display("Covered %0d maps and %0d lookups: %0d hits, %0d misses, %0d without a free slot.",
             sb.n_status[STAT_MAPPED] + sb.n_status[STAT_FULL],
             sb.n_status[STAT_HIT] + sb.n_status[STAT_MISS],
             sb.n_status[STAT_HIT], sb.n_status[STAT_MISS], sb.n_status[STAT_FULL]);
    $display("Allocated %0d tables, walked %0d stray directory pointers, used %0d frames.",
             sb.n_alloc, sb.n_stray, sb.n_frames);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("ERROR: %0d mismatching results", sb.mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
